FILE: hw/rtl/tsd_pkg.sv
// Package for the thermometer scratchpad decoder: frame constants, decode
// masks and the byte-wide 1-Wire CRC-8 update function.
// No dependencies.
package tsd_pkg;

  // Scratchpad frame layout
  localparam int unsigned FrameBytes  = 9;
  localparam int unsigned PosWidth    = 4;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned TempWidth   = 16;

  // Byte slots that the decode reads
  localparam logic [2:0] SlotTempLsb  = 3'd0;
  localparam logic [2:0] SlotTempMsb  = 3'd1;
  localparam logic [2:0] SlotConfig   = 3'd4;
  localparam logic [2:0] SlotCntRem   = 3'd6;
  localparam logic [2:0] SlotCntPerC  = 3'd7;

  // Position of the CRC byte; every lower position is folded into the CRC
  localparam logic [PosWidth-1:0] PosCrcByte = PosWidth'(FrameBytes - 1);

  // CRC-8, reflected polynomial
  localparam logic [ByteWidth-1:0] CrcPoly = 8'h8C;

  // Decode constants
  localparam logic [ByteWidth-1:0] CntPerDegLegacy = 8'h10;
  localparam logic [TempWidth-1:0] LegacyMask      = 16'hFFF0;
  localparam logic [TempWidth-1:0] LegacyBias      = 16'd12;

  // Resolution codes from config byte bits 6:5
  typedef enum logic [1:0] {
    RES_9BIT  = 2'b00,
    RES_10BIT = 2'b01,
    RES_11BIT = 2'b10,
    RES_12BIT = 2'b11
  } res_code_e;

  // Result status codes
  localparam logic StatusOk     = 1'b0;
  localparam logic StatusCrcErr = 1'b1;

  // Fold one byte into the running CRC, LSB first
  function automatic logic [ByteWidth-1:0] crc8_update(
    input logic [ByteWidth-1:0] crc_in,
    input logic [ByteWidth-1:0] data_in
  );
    logic [ByteWidth-1:0] crc;
    logic [ByteWidth-1:0] data;
    logic                 mix;
    crc  = crc_in;
    data = data_in;
    for (int i = 0; i < ByteWidth; i++) begin
      mix  = crc[0] ^ data[0];
      crc  = crc >> 1;
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
      data = data >> 1;
    end
    return crc;
  endfunction

endpackage

FILE: hw/rtl/tsd_byte_if.sv
// Scratchpad byte channel: valid/ready handshake with one byte and a
// frame start mark per beat. Depends on tsd_pkg.
interface tsd_byte_if;
  import tsd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] scratch_byte;
  logic                 frame_start;

  modport source (output valid, output scratch_byte, output frame_start, input ready);
  modport sink   (input valid, input scratch_byte, input frame_start, output ready);
endinterface

FILE: hw/rtl/tsd_result_if.sv
// Result channel: valid/ready handshake carrying the decoded temperature
// and its status per beat. Depends on tsd_pkg.
interface tsd_result_if;
  import tsd_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [TempWidth-1:0] temperature;
  logic                        status;

  modport source (output valid, output temperature, output status, input ready);
  modport sink   (input valid, input temperature, input status, output ready);
endinterface

FILE: hw/rtl/tsd_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying the legacy
// decode select. No dependencies.
interface tsd_cfg_if;
  logic valid;
  logic ready;
  logic legacy_model;

  modport source (output valid, output legacy_model, input ready);
  modport sink   (input valid, input legacy_model, output ready);
endinterface

FILE: hw/rtl/thermometer_scratchpad_decoder.sv
// Thermometer scratchpad decoder: top level.
// Depends on tsd_pkg, tsd_byte_if, tsd_result_if and tsd_cfg_if.
//
// Usage:
//   byte_i   carries the nine scratchpad bytes of a frame, byte 0 first. A beat
//            with frame_start set restarts the byte count and the CRC.
//   result_o gives one beat per frame, on the ninth byte: status 0 with a
//            signed Q8.8 temperature, or status 1 with temperature 0 when
//            the CRC over bytes 0..7 does not match the ninth byte.
//   cfg_i    writes legacy_model; it is always ready. The user must write it
//            only while the decoder is idle; the block does not enforce this.
// Timing: one byte is taken every cycle unless stalled. The CRC is folded in
//   and the needed bytes are stored in the cycle of the beat; the result
//   register is loaded on the edge that takes the ninth byte, so the result
//   is valid in the next cycle. Latency is set by that single result register.
// Stall: while a result waits in the output register and result_o.ready is
//   low, byte_i.ready drops; a taken result frees the register in the same
//   cycle, so a waiting receiver that is ready never slows the byte stream.
// Reset: rst_ni clears the byte count, the CRC, legacy_model and the result
//   valid flag; stored bytes are rewritten by every frame before use.
module thermometer_scratchpad_decoder (
  input  logic clk_i,
  input  logic rst_ni,
  tsd_byte_if.sink     byte_i,
  tsd_cfg_if.sink      cfg_i,
  tsd_result_if.source result_o
);
  import tsd_pkg::*;

  logic                 legacy_q;
  logic [PosWidth-1:0]  pos_q, pos_d;
  logic [ByteWidth-1:0] crc_q, crc_d;

  // Held scratchpad bytes that the decode reads
  logic [ByteWidth-1:0] lsb_q, msb_q, cfg_byte_q, cnt_rem_q, cnt_per_q;

  logic                        out_valid_q, out_valid_d;
  logic signed [TempWidth-1:0] temp_q;
  logic                        status_q;

  logic                 accept;
  logic [PosWidth-1:0]  pos_eff;
  logic [ByteWidth-1:0] crc_eff;
  logic                 store_beat;
  logic                 last_beat;

  logic [TempWidth-1:0] raw_word;
  logic [TempWidth-1:0] legacy_word;
  logic [TempWidth-1:0] res_word;
  logic [TempWidth-1:0] sel_word;
  logic [TempWidth-1:0] final_word;
  res_code_e            res_code;

  // Take a byte while the result slot is free or being emptied
  assign byte_i.ready = !out_valid_q || result_o.ready;
  assign accept       = byte_i.valid && byte_i.ready;
  assign cfg_i.ready  = 1'b1;

  // Frame start restarts count and CRC before the byte is used
  assign pos_eff    = byte_i.frame_start ? '0 : pos_q;
  assign crc_eff    = byte_i.frame_start ? '0 : crc_q;
  assign store_beat = accept && (pos_eff < PosCrcByte);
  assign last_beat  = accept && !(pos_eff < PosCrcByte);

  // Advance byte count and CRC
  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (store_beat) begin
      pos_d = pos_eff + PosWidth'(1);
      crc_d = crc8_update(crc_eff, byte_i.scratch_byte);
    end else if (last_beat) begin
      pos_d = '0;
      crc_d = '0;
    end
  end

  // Decode the temperature word from the held bytes
  assign raw_word    = {msb_q, lsb_q};
  assign res_code    = res_code_e'(cfg_byte_q[6:5]);

  always_comb begin
    legacy_word = raw_word << 3;
    if (cnt_per_q == CntPerDegLegacy) begin
      legacy_word = (legacy_word & LegacyMask) + LegacyBias
                    - {{(TempWidth-ByteWidth){1'b0}}, cnt_rem_q};
    end
  end

  always_comb begin
    case (res_code)
      RES_9BIT:  res_word = {raw_word[TempWidth-1:3], 3'b000};
      RES_10BIT: res_word = {raw_word[TempWidth-1:2], 2'b00};
      RES_11BIT: res_word = {raw_word[TempWidth-1:1], 1'b0};
      RES_12BIT: res_word = raw_word;
      default:   res_word = raw_word;
    endcase
  end

  assign sel_word   = legacy_q ? legacy_word : res_word;
  assign final_word = sel_word << 4;

  // Result slot: load on the ninth byte, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (last_beat) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= '0;
      legacy_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        legacy_q <= cfg_i.legacy_model;
      end
    end
  end

  // Hold the bytes the decode needs
  always_ff @(posedge clk_i) begin
    if (store_beat) begin
      case (pos_eff[2:0])
        SlotTempLsb: lsb_q     <= byte_i.scratch_byte;
        SlotTempMsb: msb_q     <= byte_i.scratch_byte;
        SlotConfig:  cfg_byte_q <= byte_i.scratch_byte;
        SlotCntRem:  cnt_rem_q <= byte_i.scratch_byte;
        SlotCntPerC: cnt_per_q <= byte_i.scratch_byte;
        default: ;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (last_beat) begin
      if (crc_eff != byte_i.scratch_byte) begin
        temp_q   <= '0;
        status_q <= StatusCrcErr;
      end else begin
        temp_q   <= final_word;
        status_q <= StatusOk;
      end
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.temperature = temp_q;
  assign result_o.status      = status_q;

endmodule

FILE: test/thermometer_scratchpad_decoder_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for thermometer_scratchpad_decoder: feeds scratchpad bytes,
// predicts every decoded reading and checks the result stream in order.
// Depends on tsd_pkg and the tsd_byte_if, tsd_result_if and tsd_cfg_if interfaces.
module thermometer_scratchpad_decoder_tb;
  import tsd_pkg::*;

  localparam int unsigned QuietLimit     = 2000;
  localparam int unsigned LongHold       = 300;
  localparam int unsigned HoldAfterBeats = 150;
  localparam int unsigned MaxWait        = 10;
  localparam int unsigned DrainCycles    = 4;
  localparam int unsigned PhaseBeats     = 270;
  localparam int unsigned ReportLimit    = 10;
  localparam int unsigned BodyBytes      = FrameBytes - 1;

  typedef struct packed {
    logic [ByteWidth-1:0] value;
    logic                 start;
  } scratch_beat_t;

  typedef struct packed {
    logic signed [TempWidth-1:0] temperature;
    logic                        status;
  } reading_t;

  logic clk_i;
  logic rst_ni;

  tsd_byte_if   byte_if ();
  tsd_result_if res_if ();
  tsd_cfg_if    cfg_if ();

  thermometer_scratchpad_decoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .cfg_i    (cfg_if),
    .result_o (res_if)
  );

  scratch_beat_t pending_bytes[$];
  reading_t      expected_readings[$];

  // Decoder state as the bench sees it
  logic [PosWidth-1:0]  model_pos;
  logic [ByteWidth-1:0] model_crc;
  logic [ByteWidth-1:0] model_held [8];
  logic                 model_legacy;

  int unsigned error_count;
  int unsigned byte_beats;
  int unsigned byte_gap;
  int unsigned result_stall;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  logic        hold_off;
  logic        hold_used;
  logic        idle_enabled;

  // Generate the clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic log_error(input string what);
    error_count++;
    if (error_count <= ReportLimit) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endtask

  function automatic int unsigned draw_wait();
    return idle_enabled ? $urandom_range(0, MaxWait) : 0;
  endfunction

  // Byte-wide 1-Wire CRC-8, LSB first
  function automatic logic [ByteWidth-1:0] crc_fold(input logic [ByteWidth-1:0] crc,
                                                    input logic [ByteWidth-1:0] b);
    logic [ByteWidth-1:0] acc;
    acc = crc;
    for (int i = 0; i < ByteWidth; i++) begin
      acc = (acc >> 1) ^ ((acc[0] ^ b[i]) ? CrcPoly : '0);
    end
    return acc;
  endfunction

  // Turn the held bytes into a Q8.8 word
  function automatic logic [TempWidth-1:0] decode_reading(input logic [ByteWidth-1:0] lsb,
                                                          input logic [ByteWidth-1:0] msb,
                                                          input logic [ByteWidth-1:0] cfg_byte,
                                                          input logic [ByteWidth-1:0] remain,
                                                          input logic [ByteWidth-1:0] per_deg,
                                                          input logic legacy);
    logic [TempWidth-1:0] w;
    w = {msb, lsb};
    if (legacy) begin
      w = w << 3;
      if (per_deg == CntPerDegLegacy) begin
        w = (w & LegacyMask) + LegacyBias - {8'h00, remain};
      end
    end else begin
      case (res_code_e'(cfg_byte[6:5]))
        RES_9BIT:  w = w & 16'hFFF8;
        RES_10BIT: w = w & 16'hFFFC;
        RES_11BIT: w = w & 16'hFFFE;
        default:   w = w;
      endcase
    end
    return w << 4;
  endfunction

  // Advance the decoder state by one accepted byte
  task automatic take_scratch_byte(input logic [ByteWidth-1:0] b, input logic start);
    reading_t r;
    if (start) begin
      model_pos = '0;
      model_crc = '0;
    end
    if (model_pos < PosCrcByte) begin
      model_held[model_pos[2:0]] = b;
      model_crc = crc_fold(model_crc, b);
      model_pos = model_pos + PosWidth'(1);
    end else begin
      if (model_crc != b) begin
        r.temperature = '0;
        r.status      = StatusCrcErr;
      end else begin
        r.temperature = decode_reading(model_held[SlotTempLsb], model_held[SlotTempMsb],
                                       model_held[SlotConfig], model_held[SlotCntRem],
                                       model_held[SlotCntPerC], model_legacy);
        r.status      = StatusOk;
      end
      expected_readings.push_back(r);
      model_pos = '0;
      model_crc = '0;
    end
  endtask

  function automatic logic [ByteWidth-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return ByteWidth'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [BodyBytes*ByteWidth-1:0] random_body(input logic legacy);
    logic [BodyBytes*ByteWidth-1:0] body;
    for (int i = 0; i < BodyBytes; i++) begin
      body[i*ByteWidth +: ByteWidth] = pick_byte();
    end
    if (legacy && $urandom_range(0, 1)) begin
      body[int'(SlotCntPerC)*ByteWidth +: ByteWidth] = CntPerDegLegacy;
    end
    return body;
  endfunction

  // Queue eight body bytes and the CRC byte, optionally corrupted
  task automatic queue_frame(input logic [BodyBytes*ByteWidth-1:0] body, input logic mark,
                             input logic bad_crc);
    logic [ByteWidth-1:0] crc;
    crc = '0;
    for (int i = 0; i < BodyBytes; i++) begin
      crc = crc_fold(crc, body[i*ByteWidth +: ByteWidth]);
      pending_bytes.push_back({body[i*ByteWidth +: ByteWidth], (i == 0) ? mark : 1'b0});
    end
    if (bad_crc) begin
      crc = crc ^ ByteWidth'($urandom_range(1, 255));
    end
    pending_bytes.push_back({crc, 1'b0});
  endtask

  task automatic write_legacy(input logic value);
    @(posedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.legacy_model <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    model_legacy = value;
    @(negedge clk_i);
  endtask

  // Wait until every queued byte is taken and every reading has come back
  task automatic settle();
    @(negedge clk_i);
    while (pending_bytes.size() != 0 || byte_if.valid || expected_readings.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Byte driver: present queued beats, idle for a drawn number of cycles after each
  always @(posedge clk_i) begin : byte_driver
    scratch_beat_t nxt;
    if (!rst_ni) begin
      byte_if.valid <= 1'b0;
      byte_gap      <= 0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        take_scratch_byte(byte_if.scratch_byte, byte_if.frame_start);
        byte_beats <= byte_beats + 1;
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (byte_gap != 0) begin
          byte_if.valid <= 1'b0;
          byte_gap      <= byte_gap - 1;
        end else if (pending_bytes.size() != 0) begin
          nxt = pending_bytes.pop_front();
          byte_if.valid        <= 1'b1;
          byte_if.scratch_byte <= nxt.value;
          byte_if.frame_start  <= nxt.start;
          byte_gap             <= draw_wait();
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each reading beat, then stall for a drawn number of cycles
  always @(posedge clk_i) begin : result_monitor
    reading_t    want;
    int unsigned stall;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      result_stall <= 0;
    end else begin
      stall = result_stall;
      if (res_if.valid && res_if.ready) begin
        if (expected_readings.size() == 0) begin
          log_error($sformatf("unexpected reading: temperature=%0d status=%0b",
                              $signed(res_if.temperature), res_if.status));
        end else begin
          want = expected_readings.pop_front();
          if (res_if.temperature !== want.temperature || res_if.status !== want.status) begin
            log_error($sformatf(
              "reading mismatch: expected temperature=%0d status=%0b, got temperature=%0d status=%0b",
              $signed(want.temperature), want.status, $signed(res_if.temperature),
              res_if.status));
          end
        end
        stall = draw_wait();
      end
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        result_stall <= stall - 1;
      end else begin
        res_if.ready <= !hold_off;
        result_stall <= 0;
      end
    end
  end

  // Hold the receiver off once for a long stretch so the decoder backs up
  always @(posedge clk_i) begin : receiver_hold
    if (!rst_ni) begin
      hold_off  <= 1'b0;
      hold_used <= 1'b0;
      hold_left <= 0;
    end else if (!hold_used && byte_beats >= HoldAfterBeats) begin
      hold_off  <= 1'b1;
      hold_used <= 1'b1;
      hold_left <= LongHold;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) begin
        hold_off <= 1'b0;
      end
    end
  end

  // Drop the run when no beat moves on any channel for too long
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready) ||
                 (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("thermometer_scratchpad_decoder_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [BodyBytes*ByteWidth-1:0] body;
    logic [5:0]                     phase_legacy;
    logic [5:0]                     phase_idle;
    int unsigned                    target;
    int unsigned                    len;
    int unsigned                    kind;

    byte_if.valid        = 1'b0;
    byte_if.scratch_byte = '0;
    byte_if.frame_start  = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.legacy_model  = 1'b0;
    res_if.ready         = 1'b0;
    error_count          = 0;
    byte_beats           = 0;
    idle_enabled         = 1'b1;
    model_legacy         = 1'b0;
    model_pos            = '0;
    model_crc            = '0;
    phase_legacy         = 6'b011010;
    phase_idle           = 6'b101111;

    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: most negative reading at full resolution
    write_legacy(1'b0);
    queue_frame({8'h10, 8'h0C, 8'hFF, 8'h7F, 8'h46, 8'h4B, 8'h08, 8'h00}, 1'b1, 1'b0);
    // All-ones frame with no start mark, counted on from position zero
    queue_frame({8{8'hFF}}, 1'b0, 1'b0);
    // Restart mid-frame, then an all-zero frame whose CRC byte is wrong
    pending_bytes.push_back({8'h5A, 1'b1});
    pending_bytes.push_back({8'hA5, 1'b0});
    queue_frame({8{8'h00}}, 1'b1, 1'b1);
    settle();

    // Random phases over both decode modes, one of them without idling
    for (int p = 0; p < 6; p++) begin
      idle_enabled = phase_idle[p];
      write_legacy(phase_legacy[p]);
      target = pending_bytes.size() + PhaseBeats;
      while (pending_bytes.size() < target) begin
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
          queue_frame(random_body(model_legacy), $urandom_range(0, 9) != 0,
                      $urandom_range(0, 4) == 0);
        end else if (kind < 90) begin
          len = $urandom_range(1, BodyBytes);
          for (int i = 0; i < len; i++) begin
            pending_bytes.push_back({pick_byte(), i == 0});
          end
        end else begin
          pending_bytes.push_back({pick_byte(), $urandom_range(0, 7) == 0});
        end
      end
      settle();
    end

    if (expected_readings.size() != 0) begin
      log_error($sformatf("%0d readings never arrived", expected_readings.size()));
    end
    if (error_count == 0) begin
      $display("thermometer_scratchpad_decoder_tb: clean");
    end else begin
      $display("thermometer_scratchpad_decoder_tb: errors");
    end
    $finish;
  end

endmodule
